>>> sv/assert_macros.svh
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication property on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition holds in the cycle after a trigger outside reset.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> sv/hwsdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hwsdg_pkg;

    localparam int POS_WIDTH_DEF   = 32;
    localparam int GROUP_WIDTH_DEF = 16;

    localparam int TIMER_W     = 16;
    localparam int PULSE_W     = 5;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int POS_OUT_W   = 32;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;

    localparam logic [4:0]  PULSES_PER_UNIT_RST = 5'd4;
    localparam logic [7:0]  HALF_PULSE_RST      = 8'd5;
    localparam logic [15:0] DWELL_RST           = 16'd100;
    localparam logic [7:0]  DIR_SETUP_RST       = 8'd2;
    localparam logic [6:0]  FINE_STEP_RST       = 7'd1;
    localparam logic [6:0]  COARSE_STEP_RST     = 7'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_UNIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PULSE      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL           = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_SETUP       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_REVERSE     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT      = 4'd7;

    localparam logic [S_TUSER_W-1:0] OP_ENCODER = 2'd0;
    localparam logic [S_TUSER_W-1:0] OP_EVENT   = 2'd1;
    localparam logic [S_TUSER_W-1:0] OP_TICK    = 2'd2;

    // Output item bit positions.
    localparam int OUT_STEP   = 0;
    localparam int OUT_DIR    = 1;
    localparam int OUT_POS_LO = 2;
    localparam int OUT_BUSY   = 34;
    localparam int OUT_COARSE = 35;
    localparam int OUT_FLAG   = 36;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_HIGH  = 3'd2,
        PH_LOW   = 3'd3,
        PH_DWELL = 3'd4
    } phase_t;

endpackage

`default_nettype wire

>>> sv/handwheel_step_dir_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item is held in the input register, and its result is written to the
// result register, from which it is offered as a result item.
// Throughput: one item per clock, set by the single state update between the input
// register and the result register; a stalled output register stops new input.
// Reset (rst_n low, asynchronous): position, step state, settings and valid flags reset.
module handwheel_step_dir_generator_unit #(
    parameter int POS_WIDTH         = hwsdg_pkg::POS_WIDTH_DEF,
    parameter int GROUP_COUNT_WIDTH = hwsdg_pkg::GROUP_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hwsdg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hwsdg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // encoder_count[7:0], zero_pressed[8], coarse_pressed[9], fine_pressed[10], zero fill
    input  wire logic [hwsdg_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  wire logic [hwsdg_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // step_level[0], dir_level[1], position[33:2], busy_res[34], coarse_mode[35],
    // event_flag[36], zero fill
    output logic [hwsdg_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int P   = POS_WIDTH;
    localparam int G   = GROUP_COUNT_WIDTH;
    localparam int TW  = hwsdg_pkg::TIMER_W;
    localparam int PW  = hwsdg_pkg::PULSE_W;
    localparam int MW  = (P > G) ? P : G + 1;
    localparam int EW  = (P > hwsdg_pkg::POS_OUT_W) ? P : hwsdg_pkg::POS_OUT_W;

    logic [4:0]  ppu_reg;
    logic [7:0]  half_reg;
    logic [15:0] dwell_reg;
    logic [7:0]  setup_reg;
    logic [6:0]  fine_reg;
    logic [6:0]  coarse_step_reg;
    logic        enc_rev_reg;
    logic        dir_inv_reg;

    logic                                 in_valid_reg;
    logic                                 in_valid_next;
    logic [hwsdg_pkg::S_TDATA_W-1:0]      in_data_reg;
    logic [hwsdg_pkg::S_TUSER_W-1:0]      in_op_reg;
    logic                                 m_tvalid_reg;
    logic                                 m_tvalid_next;
    logic [hwsdg_pkg::M_TDATA_W-1:0]      m_tdata_reg;
    logic [hwsdg_pkg::M_TDATA_W-1:0]      m_tdata_next;

    logic [P-1:0]      pos_reg, pos_next;
    logic [P-1:0]      last_reg, last_next;
    logic              coarse_sel_reg, coarse_sel_next;
    logic [2:0]        btn_reg, btn_next;
    hwsdg_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]     timer_reg, timer_next;
    logic [PW-1:0]     pulses_reg, pulses_next;
    logic [G-1:0]      groups_reg, groups_next;
    logic              dir_reg, dir_next;
    logic              step_reg, step_next;

    logic          advance, s_accept;
    logic          is_enc, is_evt, is_tick, busy;
    logic [2:0]    buttons, rising;
    logic [P-1:0]  pos_z, diff, ndiff, mag;
    logic [MW-1:0] mag_ext;
    logic          neg, sat, start, flag;
    logic [G-1:0]  group_start;
    logic [TW-1:0] timer_dec, half_t;
    logic          expire;
    logic [PW-1:0] pulses_dec, ppu_eff;
    logic          more_pulses;
    logic [G-1:0]  groups_dec;
    logic          more_groups;
    logic [P-1:0]  inc;
    logic          down;
    logic [EW-1:0] pos_ext;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign is_enc  = advance && (in_op_reg == hwsdg_pkg::OP_ENCODER);
    assign is_evt  = advance && (in_op_reg == hwsdg_pkg::OP_EVENT);
    assign is_tick = advance && (in_op_reg == hwsdg_pkg::OP_TICK);
    assign busy    = (phase_reg != hwsdg_pkg::PH_IDLE);

    assign buttons = in_data_reg[10:8];
    assign rising  = buttons & ~btn_reg;
    assign pos_z   = rising[0] ? '0 : pos_reg;
    assign diff    = pos_z - last_reg;
    assign ndiff   = last_reg - pos_z;
    assign neg     = diff[P-1];
    assign mag     = neg ? ndiff : diff;
    assign mag_ext = MW'(mag);
    assign sat     = (mag_ext[MW-1:G] != '0);
    assign group_start = sat ? {G{1'b1}} : mag_ext[G-1:0];
    assign start   = is_evt && !busy && (pos_z != last_reg);
    assign flag    = is_evt && (busy || (start && sat));

    assign timer_dec   = (timer_reg == '0) ? '0 : timer_reg - TW'(1);
    assign expire      = is_tick && busy && (timer_dec == '0);
    assign pulses_dec  = (pulses_reg == '0) ? '0 : pulses_reg - PW'(1);
    assign more_pulses = (pulses_dec != '0);
    assign groups_dec  = (groups_reg == '0) ? '0 : groups_reg - G'(1);
    assign more_groups = (groups_dec != '0);
    assign ppu_eff     = (ppu_reg == '0) ? PW'(1) : ppu_reg;
    assign half_t      = (half_reg == '0) ? TW'(1) : TW'(half_reg);

    assign inc  = P'(coarse_sel_reg ? coarse_step_reg : fine_reg);
    assign down = in_data_reg[7] ^ enc_rev_reg;

    // Phase sequencing.
    always_comb
    begin
        phase_next = phase_reg;
        if (start)
        begin
            phase_next = (setup_reg == '0) ? hwsdg_pkg::PH_HIGH : hwsdg_pkg::PH_SETUP;
        end
        else if (expire)
        begin
            unique case (phase_reg)
                hwsdg_pkg::PH_SETUP: phase_next = hwsdg_pkg::PH_HIGH;
                hwsdg_pkg::PH_HIGH:  phase_next = hwsdg_pkg::PH_LOW;
                hwsdg_pkg::PH_LOW:
                begin
                    if (more_pulses)
                        phase_next = hwsdg_pkg::PH_HIGH;
                    else if (dwell_reg != '0)
                        phase_next = hwsdg_pkg::PH_DWELL;
                    else if (more_groups)
                        phase_next = hwsdg_pkg::PH_HIGH;
                    else
                        phase_next = hwsdg_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = more_groups ? hwsdg_pkg::PH_HIGH : hwsdg_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Timers, counters, outputs and position.
    always_comb
    begin
        pos_next        = pos_reg;
        last_next       = last_reg;
        coarse_sel_next = coarse_sel_reg;
        btn_next        = btn_reg;
        timer_next      = timer_reg;
        pulses_next     = pulses_reg;
        groups_next     = groups_reg;
        dir_next        = dir_reg;
        step_next       = step_reg;

        if (is_enc && (in_data_reg[7:0] != '0))
        begin
            pos_next = down ? pos_reg - inc : pos_reg + inc;
        end

        if (is_evt && !busy)
        begin
            pos_next = pos_z;
            btn_next = buttons;
            if (rising[1])
                coarse_sel_next = 1'b1;
            if (rising[2])
                coarse_sel_next = 1'b0;
        end

        if (start)
        begin
            last_next   = pos_z;
            dir_next    = !neg ^ dir_inv_reg;
            groups_next = group_start;
            if (setup_reg == '0)
            begin
                pulses_next = ppu_eff;
                step_next   = 1'b1;
                timer_next  = half_t;
            end
            else
            begin
                timer_next = TW'(setup_reg);
            end
        end
        else if (is_tick && busy)
        begin
            timer_next = timer_dec;
            if (expire)
            begin
                unique case (phase_reg)
                    hwsdg_pkg::PH_SETUP:
                    begin
                        pulses_next = ppu_eff;
                        step_next   = 1'b1;
                        timer_next  = half_t;
                    end
                    hwsdg_pkg::PH_HIGH:
                    begin
                        step_next  = 1'b0;
                        timer_next = half_t;
                    end
                    hwsdg_pkg::PH_LOW:
                    begin
                        pulses_next = pulses_dec;
                        if (more_pulses)
                        begin
                            step_next  = 1'b1;
                            timer_next = half_t;
                        end
                        else if (dwell_reg != '0)
                        begin
                            timer_next = dwell_reg;
                        end
                        else
                        begin
                            groups_next = groups_dec;
                            if (more_groups)
                            begin
                                pulses_next = ppu_eff;
                                step_next   = 1'b1;
                                timer_next  = half_t;
                            end
                            else
                            begin
                                pulses_next = '0;
                                timer_next  = '0;
                            end
                        end
                    end
                    default:
                    begin
                        groups_next = groups_dec;
                        if (more_groups)
                        begin
                            pulses_next = ppu_eff;
                            step_next   = 1'b1;
                            timer_next  = half_t;
                        end
                        else
                        begin
                            pulses_next = '0;
                            timer_next  = '0;
                        end
                    end
                endcase
            end
        end
    end

    assign pos_ext = EW'(pos_next);

    always_comb
    begin
        m_tdata_next = '0;
        m_tdata_next[hwsdg_pkg::OUT_STEP] = step_next;
        m_tdata_next[hwsdg_pkg::OUT_DIR]  = dir_next;
        m_tdata_next[hwsdg_pkg::OUT_POS_LO +: hwsdg_pkg::POS_OUT_W] =
            pos_ext[hwsdg_pkg::POS_OUT_W-1:0];
        m_tdata_next[hwsdg_pkg::OUT_BUSY]   = (phase_next != hwsdg_pkg::PH_IDLE);
        m_tdata_next[hwsdg_pkg::OUT_COARSE] = coarse_sel_next;
        m_tdata_next[hwsdg_pkg::OUT_FLAG]   = flag;
    end

    assign in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign m_tvalid_next = advance ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppu_reg         <= hwsdg_pkg::PULSES_PER_UNIT_RST;
            half_reg        <= hwsdg_pkg::HALF_PULSE_RST;
            dwell_reg       <= hwsdg_pkg::DWELL_RST;
            setup_reg       <= hwsdg_pkg::DIR_SETUP_RST;
            fine_reg        <= hwsdg_pkg::FINE_STEP_RST;
            coarse_step_reg <= hwsdg_pkg::COARSE_STEP_RST;
            enc_rev_reg     <= 1'b0;
            dir_inv_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hwsdg_pkg::CFG_PULSES_PER_UNIT: ppu_reg         <= cfg_data[4:0];
                hwsdg_pkg::CFG_HALF_PULSE:      half_reg        <= cfg_data[7:0];
                hwsdg_pkg::CFG_DWELL:           dwell_reg       <= cfg_data[15:0];
                hwsdg_pkg::CFG_DIR_SETUP:       setup_reg       <= cfg_data[7:0];
                hwsdg_pkg::CFG_FINE_STEP:       fine_reg        <= cfg_data[6:0];
                hwsdg_pkg::CFG_COARSE_STEP:     coarse_step_reg <= cfg_data[6:0];
                hwsdg_pkg::CFG_ENC_REVERSE:     enc_rev_reg     <= cfg_data[0];
                hwsdg_pkg::CFG_DIR_INVERT:      dir_inv_reg     <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            pos_reg        <= '0;
            last_reg       <= '0;
            coarse_sel_reg <= 1'b0;
            btn_reg        <= '0;
            phase_reg      <= hwsdg_pkg::PH_IDLE;
            timer_reg      <= '0;
            pulses_reg     <= '0;
            groups_reg     <= '0;
            dir_reg        <= 1'b0;
            step_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            pos_reg        <= pos_next;
            last_reg       <= last_next;
            coarse_sel_reg <= coarse_sel_next;
            btn_reg        <= btn_next;
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            pulses_reg     <= pulses_next;
            groups_reg     <= groups_next;
            dir_reg        <= dir_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
        if (advance)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/hwsdg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hwsdg_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [hwsdg_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A stalled result item keeps its valid and its contents.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")

    // The step output is only high while a sequence runs.
    `ASSERT_CLKD(a_step_busy, clk, rst_n, m_tvalid |-> (!m_tdata[hwsdg_pkg::OUT_STEP] || m_tdata[hwsdg_pkg::OUT_BUSY]), "step high while not busy")

    // A flagged event either found the block busy or started a sequence.
    `ASSERT_CLKD(a_flag_busy, clk, rst_n, m_tvalid |-> (!m_tdata[hwsdg_pkg::OUT_FLAG] || m_tdata[hwsdg_pkg::OUT_BUSY]), "event flag without busy")

    // With the output stalled, one buffered item is all the input side takes.
    `ASSERT_CLKD(a_in_backpressure, clk, rst_n, (m_tvalid && !m_tready && s_tvalid && s_tready ##1 !m_tready) |-> !s_tready, "input accepted past a stalled output")

endmodule

bind handwheel_step_dir_generator_unit hwsdg_checker u_hwsdg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> verif/tb_handwheel_step_dir_generator_unit.sv
`timescale 1ns / 1ps

module tb_handwheel_step_dir_generator_unit;
    import hwsdg_pkg::*;

    localparam int POS_W = 32;
    localparam int GROUP_W = 16;
    localparam logic [GROUP_W-1:0] GROUP_SAT = '1;

    localparam logic [S_TUSER_W-1:0] OP_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    localparam logic [2:0] BTN_NONE = 3'b000;
    localparam logic [2:0] BTN_ZERO = 3'b001;
    localparam logic [2:0] BTN_COARSE = 3'b010;
    localparam logic [2:0] BTN_FINE = 3'b100;

    typedef struct {
        logic [1:0] op;
        logic signed [7:0] enc;
        logic zero;
        logic coarse;
        logic fine;
    } wheel_item_t;

    typedef struct {
        logic step;
        logic dir;
        logic [POS_W-1:0] position;
        logic busy;
        logic coarse;
        logic flag;
    } wheel_status_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = OP_TICK;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    handwheel_step_dir_generator_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Settings and state of the stepper as the testbench expects them.
    logic [4:0] ppu_cfg = PULSES_PER_UNIT_RST;
    logic [7:0] half_cfg = HALF_PULSE_RST;
    logic [15:0] dwell_cfg = DWELL_RST;
    logic [7:0] setup_cfg = DIR_SETUP_RST;
    logic [6:0] fine_cfg = FINE_STEP_RST;
    logic [6:0] coarse_cfg = COARSE_STEP_RST;
    logic rev_cfg = 1'b0;
    logic inv_cfg = 1'b0;

    logic [POS_W-1:0] pos_q = '0;
    logic [POS_W-1:0] last_out_q = '0;
    logic coarse_q = 1'b0;
    logic [2:0] btn_prev_q = '0;
    phase_t ph_q = PH_IDLE;
    logic [15:0] timer_q = '0;
    logic [4:0] pulses_q = '0;
    logic [GROUP_W-1:0] groups_q = '0;
    logic dir_q = 1'b0;
    logic step_q = 1'b0;

    wheel_item_t wheel_items[$];
    wheel_status_t status_due[$];
    wheel_item_t offer;
    int burst_left = 0;
    int gap_left = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int rx_span = 0;
    int rx_hold = 0;
    int rx_count = 0;
    int next_hold_at = 600;
    int results_seen = 0;
    int n_errors = 0;

    function automatic logic [15:0] pulse_half();
        return (half_cfg == 8'd0) ? 16'd1 : 16'(half_cfg);
    endfunction

    function automatic void start_group();
        pulses_q = (ppu_cfg == 5'd0) ? 5'd1 : ppu_cfg;
        ph_q = PH_HIGH;
        step_q = 1'b1;
        timer_q = pulse_half();
    endfunction

    function automatic void close_group();
        if (groups_q != 0)
            groups_q--;
        if (groups_q != 0)
            start_group();
        else
        begin
            ph_q = PH_IDLE;
            timer_q = '0;
            pulses_q = '0;
        end
    endfunction

    function automatic void advance_tick();
        if (ph_q == PH_IDLE)
            return;
        if (timer_q != 0)
            timer_q--;
        if (timer_q != 0)
            return;
        case (ph_q)
            PH_SETUP:
                start_group();
            PH_HIGH:
            begin
                ph_q = PH_LOW;
                step_q = 1'b0;
                timer_q = pulse_half();
            end
            PH_LOW:
            begin
                if (pulses_q != 0)
                    pulses_q--;
                if (pulses_q != 0)
                begin
                    ph_q = PH_HIGH;
                    step_q = 1'b1;
                    timer_q = pulse_half();
                end
                else if (dwell_cfg == 16'd0)
                    close_group();
                else
                begin
                    ph_q = PH_DWELL;
                    timer_q = dwell_cfg;
                end
            end
            default:
                close_group();
        endcase
    endfunction

    function automatic logic apply_buttons(logic [2:0] btn);
        logic [2:0] rising;
        logic [POS_W-1:0] delta;
        logic [POS_W-1:0] mag;
        logic neg;
        logic sat;
        rising = btn & ~btn_prev_q;
        sat = 1'b0;
        if (rising[0])
            pos_q = '0;
        if (rising[1])
            coarse_q = 1'b1;
        if (rising[2])
            coarse_q = 1'b0;
        btn_prev_q = btn;
        if (pos_q == last_out_q)
            return 1'b0;
        delta = pos_q - last_out_q;
        neg = delta[POS_W-1];
        mag = neg ? -delta : delta;
        if (mag > POS_W'(GROUP_SAT))
        begin
            mag = POS_W'(GROUP_SAT);
            sat = 1'b1;
        end
        last_out_q = pos_q;
        dir_q = ~neg ^ inv_cfg;
        groups_q = mag[GROUP_W-1:0];
        if (setup_cfg == 8'd0)
            start_group();
        else
        begin
            ph_q = PH_SETUP;
            timer_q = 16'(setup_cfg);
        end
        return sat;
    endfunction

    function automatic wheel_status_t predict_status(wheel_item_t it);
        wheel_status_t r;
        logic [POS_W-1:0] inc;
        r.flag = 1'b0;
        case (it.op)
            OP_ENCODER:
                if (it.enc != 0)
                begin
                    inc = coarse_q ? POS_W'(coarse_cfg) : POS_W'(fine_cfg);
                    if (it.enc[7] ^ rev_cfg)
                        pos_q = pos_q - inc;
                    else
                        pos_q = pos_q + inc;
                end
            OP_EVENT:
                if (ph_q != PH_IDLE)
                    r.flag = 1'b1;
                else
                    r.flag = apply_buttons({it.fine, it.coarse, it.zero});
            OP_TICK:
                advance_tick();
            default:
                ;
        endcase
        r.step = step_q;
        r.dir = dir_q;
        r.position = pos_q;
        r.busy = (ph_q != PH_IDLE);
        r.coarse = coarse_q;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                status_due.push_back(predict_status(offer));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (wheel_items.size() > 0)
                begin
                    offer = wheel_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, offer.fine, offer.coarse, offer.zero, offer.enc};
                    s_tuser <= offer.op;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 20);
                        gap_left = $urandom_range(0, 5);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        wheel_status_t want;
        wheel_status_t got;
        if (rst_n)
        begin
            rx_count++;
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got.step = m_tdata[OUT_STEP];
                got.dir = m_tdata[OUT_DIR];
                got.position = m_tdata[OUT_POS_LO +: POS_OUT_W];
                got.busy = m_tdata[OUT_BUSY];
                got.coarse = m_tdata[OUT_COARSE];
                got.flag = m_tdata[OUT_FLAG];
                if (status_due.size() == 0)
                begin
                    $error("unexpected result item %0h", m_tdata);
                    n_errors++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("step_level", want.step, got.step);
                    check_field("dir_level", want.dir, got.dir);
                    check_field("position", want.position, got.position);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("coarse_mode", want.coarse, got.coarse);
                    check_field("event_flag", want.flag, got.flag);
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (results_seen >= next_hold_at)
            begin
                rx_hold = 300;
                next_hold_at += 1200;
                m_tready <= 1'b0;
            end
            else
            begin
                if (rx_span == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_span = $urandom_range(16, 96);
                end
                else
                    rx_span--;
                case (rx_mode)
                    RX_OPEN:
                        m_tready <= 1'b1;
                    RX_COIN:
                        m_tready <= ($urandom_range(0, 1) == 1);
                    RX_COMB:
                        m_tready <= (rx_count % 4 != 3);
                    default:
                        m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic void push(logic [1:0] op, logic [7:0] enc, logic [2:0] btn);
        wheel_items.push_back('{op, enc, btn[0], btn[1], btn[2]});
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (wheel_items.size() != 0 || s_tvalid || status_due.size() != 0);
    endtask

    task automatic run_out_sequence();
        wait_drained();
        while (ph_q != PH_IDLE)
        begin
            repeat (64)
                push(OP_TICK, 8'($urandom), 3'($urandom));
            wait_drained();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PULSES_PER_UNIT: ppu_cfg = val[4:0];
            CFG_HALF_PULSE: half_cfg = val[7:0];
            CFG_DWELL: dwell_cfg = val;
            CFG_DIR_SETUP: setup_cfg = val[7:0];
            CFG_FINE_STEP: fine_cfg = val[6:0];
            CFG_COARSE_STEP: coarse_cfg = val[6:0];
            CFG_ENC_REVERSE: rev_cfg = val[0];
            CFG_DIR_INVERT: inv_cfg = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input int ppu, half, dwell, setup, fine, coarse, rev, inv,
                                 input bit junk);
        logic [15:0] noise;
        noise = junk ? 16'($urandom) : 16'd0;
        write_reg(CFG_PULSES_PER_UNIT, 16'(ppu) | (noise & 16'hFFE0));
        write_reg(CFG_HALF_PULSE, 16'(half) | (noise & 16'hFF00));
        write_reg(CFG_DWELL, 16'(dwell));
        write_reg(CFG_DIR_SETUP, 16'(setup) | (noise & 16'hFF00));
        write_reg(CFG_FINE_STEP, 16'(fine) | (noise & 16'hFF80));
        write_reg(CFG_COARSE_STEP, 16'(coarse) | (noise & 16'hFF80));
        write_reg(CFG_ENC_REVERSE, 16'(rev) | (noise & 16'hFFFE));
        write_reg(CFG_DIR_INVERT, 16'(inv) | (noise & 16'hFFFE));
    endtask

    initial
    begin
        int pick;
        logic [7:0] count;
        logic [2:0] btn;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: fine step 1, coarse step 10, default timing.
        push(OP_TICK, 8'd0, BTN_NONE);
        push(OP_RESERVED, 8'($urandom), 3'($urandom));
        push(OP_ENCODER, 8'sd127, BTN_NONE);
        push(OP_ENCODER, 8'h80, BTN_NONE);
        push(OP_ENCODER, 8'd0, BTN_ZERO | BTN_COARSE | BTN_FINE);
        push(OP_EVENT, 8'd0, BTN_NONE);
        push(OP_ENCODER, 8'd1, BTN_NONE);
        push(OP_ENCODER, 8'd5, BTN_NONE);
        push(OP_EVENT, 8'hFF, BTN_COARSE | BTN_FINE);
        push(OP_EVENT, 8'd0, BTN_ZERO);
        push(OP_ENCODER, 8'hFF, BTN_NONE);
        repeat (3)
            push(OP_TICK, 8'd0, BTN_NONE);
        run_out_sequence();
        push(OP_EVENT, 8'd0, BTN_NONE);
        run_out_sequence();
        push(OP_EVENT, 8'd0, BTN_COARSE);
        push(OP_ENCODER, 8'd3, BTN_NONE);
        push(OP_EVENT, 8'd0, BTN_ZERO | BTN_COARSE);
        run_out_sequence();

        for (int k = 0; k < 7; k++)
        begin
            case (k)
                0: load_settings(0, 0, 0, 0, 1, 1, 0, 0, 1'b0);
                1: load_settings(16, 1, 1, 1, 1, 2, 1, 1, 1'b0);
                2: load_settings($urandom_range(1, 3), $urandom_range(1, 2),
                                 $urandom_range(0, 3), $urandom_range(0, 3),
                                 $urandom_range(1, 2), $urandom_range(1, 4),
                                 $urandom_range(0, 1), $urandom_range(0, 1), 1'b1);
                default:
                begin
                    if (k == 3)
                    begin
                        write_reg(CFG_UNUSED_LO, 16'($urandom));
                        write_reg(CFG_UNUSED_HI, 16'($urandom));
                    end
                    load_settings($urandom_range(1, 3), $urandom_range(1, 2),
                                  $urandom_range(0, 3), $urandom_range(0, 3),
                                  $urandom_range(1, 2), $urandom_range(1, 4),
                                  $urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
                end
            endcase
            repeat (80)
            begin
                pick = $urandom_range(0, 99);
                count = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
                btn = {1'($urandom), 1'($urandom), ($urandom_range(0, 7) == 0)};
                if (pick < 74)
                    push(OP_TICK, 8'($urandom), 3'($urandom));
                else if (pick < 86)
                    push(OP_ENCODER, count, 3'($urandom));
                else if (pick < 98)
                    push(OP_EVENT, 8'($urandom), btn);
                else
                    push(OP_RESERVED, 8'($urandom), 3'($urandom));
            end
            run_out_sequence();
        end

        // Leave the block idle with no change pending, then push a change past
        // the group counter range under the slowest timing.
        push(OP_EVENT, 8'd0, BTN_NONE);
        run_out_sequence();
        load_settings(1, 255, 65535, 255, 127, 127, 1, 1, 1'b0);
        push(OP_EVENT, 8'd0, BTN_COARSE);
        repeat (520)
            push(OP_ENCODER, 8'($urandom_range(1, 127)), BTN_NONE);
        push(OP_EVENT, 8'd0, BTN_COARSE);
        repeat (300)
            push(OP_TICK, 8'd0, BTN_NONE);
        push(OP_EVENT, 8'd0, BTN_FINE);
        push(OP_ENCODER, 8'h80, BTN_NONE);
        repeat (40)
            push(OP_TICK, 8'd0, BTN_NONE);
        wait_drained();
        repeat (16)
            @(posedge clk);
        if (n_errors == 0)
            $display("** handwheel_step_dir_generator_unit: PASSED **");
        else
            $display("** handwheel_step_dir_generator_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("** handwheel_step_dir_generator_unit: FAILED **");
        $finish;
    end

endmodule
